>>> design/flat_json_stream_parser_macros.svh
// assertion macros shared by the parser rtl
`ifndef FLAT_JSON_STREAM_PARSER_MACROS_SVH
`define FLAT_JSON_STREAM_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define FJSP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define FJSP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/fjsp_pkg.sv
// shared types, codes and character helpers for the json stream parser
package fjsp_pkg;

   // parser phases
   localparam logic [3:0] PH_START     = 4'd0;
   localparam logic [3:0] PH_ARR_FIRST = 4'd1;
   localparam logic [3:0] PH_OBJ_FIRST = 4'd2;
   localparam logic [3:0] PH_KEY       = 4'd3;
   localparam logic [3:0] PH_COLON     = 4'd4;
   localparam logic [3:0] PH_VALUE     = 4'd5;
   localparam logic [3:0] PH_STR       = 4'd6;
   localparam logic [3:0] PH_LIT       = 4'd7;
   localparam logic [3:0] PH_NUM       = 4'd8;
   localparam logic [3:0] PH_OBJ_AFTER = 4'd9;
   localparam logic [3:0] PH_OBJ_KEY   = 4'd10;
   localparam logic [3:0] PH_ARR_AFTER = 4'd11;
   localparam logic [3:0] PH_ARR_OBJ   = 4'd12;
   localparam logic [3:0] PH_DONE      = 4'd13;

   // event kinds
   localparam logic [3:0] EV_KEY_CHAR  = 4'd0;
   localparam logic [3:0] EV_KEY_END   = 4'd1;
   localparam logic [3:0] EV_STR_CHAR  = 4'd2;
   localparam logic [3:0] EV_STR_END   = 4'd3;
   localparam logic [3:0] EV_INT       = 4'd4;
   localparam logic [3:0] EV_BOOL      = 4'd5;
   localparam logic [3:0] EV_NULL      = 4'd6;
   localparam logic [3:0] EV_OBJ_OPEN  = 4'd7;
   localparam logic [3:0] EV_OBJ_CLOSE = 4'd8;
   localparam logic [3:0] EV_ARR_OPEN  = 4'd9;
   localparam logic [3:0] EV_ARR_CLOSE = 4'd10;
   localparam logic [3:0] EV_ERROR     = 4'd11;

   // literal selectors
   localparam logic [1:0] LIT_TRUE  = 2'd0;
   localparam logic [1:0] LIT_FALSE = 2'd1;
   localparam logic [1:0] LIT_NULL  = 2'd2;

   localparam int MAX_EVENTS = 3;

   // one result event
   typedef struct packed {
      logic [3:0]  kind;
      logic [63:0] data;
      logic        fin;
      logic        last;
   } ev_type;

   // all events caused by one input byte
   typedef struct packed {
      logic [1:0]                  count;
      ev_type [MAX_EVENTS-1:0]     ev;
   } bundle_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   // n, r and t map to control characters, the rest pass through
   function automatic logic [7:0] decode_escape(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h6e: r = 8'h0a;
         8'h72: r = 8'h0d;
         8'h74: r = 8'h09;
         default: r = b;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] lit_len(input logic [1:0] w);
      return (w == LIT_FALSE) ? 3'd5 : 3'd4;
   endfunction

   // expected letter of true, false or null at a position
   function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] pos);
      logic [7:0] r;
      case ({w, pos})
         {LIT_TRUE, 3'd0}:  r = 8'h74;
         {LIT_TRUE, 3'd1}:  r = 8'h72;
         {LIT_TRUE, 3'd2}:  r = 8'h75;
         {LIT_TRUE, 3'd3}:  r = 8'h65;
         {LIT_FALSE, 3'd0}: r = 8'h66;
         {LIT_FALSE, 3'd1}: r = 8'h61;
         {LIT_FALSE, 3'd2}: r = 8'h6c;
         {LIT_FALSE, 3'd3}: r = 8'h73;
         {LIT_FALSE, 3'd4}: r = 8'h65;
         {LIT_NULL, 3'd0}:  r = 8'h6e;
         {LIT_NULL, 3'd1}:  r = 8'h75;
         {LIT_NULL, 3'd2}:  r = 8'h6c;
         {LIT_NULL, 3'd3}:  r = 8'h6c;
         2'd3 << 3:         r = 8'h6e;
         (2'd3 << 3) | 5'd1: r = 8'h75;
         (2'd3 << 3) | 5'd2: r = 8'h6c;
         (2'd3 << 3) | 5'd3: r = 8'h6c;
         default:           r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

>>> design/flat_json_stream_parser.sv
// Streaming parser for flat JSON objects (or, with array_mode set, an array of
// them); each input transaction carries one byte of the document. Each byte is
// decoded by a state machine with a times-ten accumulator and yields zero to
// three events, which go into a small result buffer and leave one per cycle
// while results are accepted, the first in the cycle after the byte is taken.
// The input is ready while the buffer is empty or its one remaining event is
// being taken, so bytes that yield at most one event each are taken every
// cycle while results are accepted; a byte with two or three events stalls the
// input while the buffer drains, and any hold-off on the result side stalls
// the input as well. Integers are reported when the byte after their last
// digit arrives. Write array_mode only between documents; the configuration
// channel is always ready.

module flat_json_stream_parser
   import fjsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,    // array_mode
   // document bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // doc_byte
   input  logic        req_tlast,   // last_of_document
   // events
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // event_data
   output logic [4:0]  rsp_tuser,   // event_kind[3:0], finished[4]
   output logic        rsp_tlast    // last_in_run
);

   logic       array_mode_ff;
   logic       accept;
   bundle_type bundle;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         array_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         array_mode_ff <= csr_data;
      end
   end

   assign accept = req_tvalid && req_tready;

   fjsp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .array_mode (array_mode_ff),
      .advance    (accept),
      .doc_byte   (req_tdata),
      .doc_last   (req_tlast),
      .bundle     (bundle)
   );

   fjsp_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (accept),
      .bundle     (bundle),
      .can_load   (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> design/fjsp_core.sv
// parser state machine: one byte in, up to three events out per transaction
`include "flat_json_stream_parser_macros.svh"

module fjsp_core
   import fjsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        array_mode,
   input  logic        advance,
   input  logic [7:0]  doc_byte,
   input  logic        doc_last,
   output bundle_type  bundle
);

   logic [3:0]  phase_ff,  phase_in;
   logic        inobj_ff,  inobj_in;
   logic        esc_ff,    esc_in;
   logic [2:0]  litpos_ff, litpos_in;
   logic [1:0]  litw_ff,   litw_in;
   logic [63:0] mag_ff,    mag_in;
   logic        neg_ff,    neg_in;
   logic        ovf_ff,    ovf_in;
   logic        closed_ff, closed_in;
   logic        err_ff,    err_in;

   logic [67:0]   prod;
   logic [63:0]   num_value;
   logic          go;
   logic          is_val;
   logic          do_open, do_close_obj, do_close_arr, do_err;
   logic [1:0]    n;
   ev_type [MAX_EVENTS-1:0] ev_a;

   // accumulator step and saturated value of the pending integer
   always_comb begin
      prod = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + {64'b0, doc_byte[3:0]};
      if (neg_ff) begin
         num_value = (ovf_ff || mag_ff > 64'h8000_0000_0000_0000) ?
                     64'h8000_0000_0000_0000 : (64'd0 - mag_ff);
      end else begin
         num_value = (ovf_ff || mag_ff[63]) ? 64'h7fff_ffff_ffff_ffff : mag_ff;
      end
   end

   // next state and event list
   always_comb begin
      phase_in  = phase_ff;
      inobj_in  = inobj_ff;
      esc_in    = esc_ff;
      litpos_in = litpos_ff;
      litw_in   = litw_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      ovf_in    = ovf_ff;
      closed_in = closed_ff;
      err_in    = err_ff;
      ev_a      = '0;
      n         = 2'd0;
      go        = 1'b0;
      is_val    = (phase_ff == PH_STR);
      do_open      = 1'b0;
      do_close_obj = 1'b0;
      do_close_arr = 1'b0;
      do_err       = 1'b0;

      if (!err_ff && !closed_ff) begin
         go = 1'b1;
         // a number ends on the first non-digit, which is then parsed
         if (phase_ff == PH_NUM) begin
            if (is_digit(doc_byte)) begin
               go = 1'b0;
               if (!ovf_ff) begin
                  if (prod[67:64] != 4'd0) begin
                     ovf_in = 1'b1;
                  end else begin
                     mag_in = prod[63:0];
                  end
               end
            end else begin
               ev_a[n].kind = EV_INT;
               ev_a[n].data = num_value;
               n = n + 2'd1;
               phase_in = PH_OBJ_AFTER;
            end
         end
         // whitespace skipped outside strings and literals
         if (go && phase_in != PH_KEY && phase_in != PH_STR && phase_in != PH_LIT &&
             phase_in != PH_DONE && is_ws(doc_byte)) begin
            go = 1'b0;
         end
         if (go) begin
            case (phase_in)
               PH_START: begin
                  if (array_mode && doc_byte == 8'h5b) begin
                     ev_a[n].kind = EV_ARR_OPEN;
                     n = n + 2'd1;
                     phase_in = PH_ARR_FIRST;
                  end else if (!array_mode && doc_byte == 8'h7b) begin
                     do_open = 1'b1;
                  end else begin
                     do_err = 1'b1;
                  end
               end
               PH_ARR_FIRST: begin
                  if (doc_byte == 8'h7b) do_open = 1'b1;
                  else if (doc_byte == 8'h5d) do_close_arr = 1'b1;
                  else do_err = 1'b1;
               end
               PH_ARR_OBJ: begin
                  if (doc_byte == 8'h7b) do_open = 1'b1;
                  else do_err = 1'b1;
               end
               PH_OBJ_FIRST: begin
                  if (doc_byte == 8'h22) phase_in = PH_KEY;
                  else if (doc_byte == 8'h7d) do_close_obj = 1'b1;
                  else do_err = 1'b1;
               end
               PH_OBJ_KEY: begin
                  if (doc_byte == 8'h22) phase_in = PH_KEY;
                  else do_err = 1'b1;
               end
               PH_KEY, PH_STR: begin
                  if (esc_ff) begin
                     esc_in = 1'b0;
                     ev_a[n].kind = is_val ? EV_STR_CHAR : EV_KEY_CHAR;
                     ev_a[n].data = {56'b0, decode_escape(doc_byte)};
                     n = n + 2'd1;
                  end else if (doc_byte == 8'h5c) begin
                     esc_in = 1'b1;
                  end else if (doc_byte == 8'h22) begin
                     ev_a[n].kind = is_val ? EV_STR_END : EV_KEY_END;
                     n = n + 2'd1;
                     phase_in = is_val ? PH_OBJ_AFTER : PH_COLON;
                  end else begin
                     ev_a[n].kind = is_val ? EV_STR_CHAR : EV_KEY_CHAR;
                     ev_a[n].data = {56'b0, doc_byte};
                     n = n + 2'd1;
                  end
               end
               PH_COLON: begin
                  if (doc_byte == 8'h3a) phase_in = PH_VALUE;
                  else do_err = 1'b1;
               end
               PH_VALUE: begin
                  mag_in    = 64'd0;
                  neg_in    = 1'b0;
                  ovf_in    = 1'b0;
                  litpos_in = 3'd1;
                  if (doc_byte == 8'h22) begin
                     phase_in = PH_STR;
                  end else if (doc_byte == 8'h74) begin
                     litw_in  = LIT_TRUE;
                     phase_in = PH_LIT;
                  end else if (doc_byte == 8'h66) begin
                     litw_in  = LIT_FALSE;
                     phase_in = PH_LIT;
                  end else if (doc_byte == 8'h6e) begin
                     litw_in  = LIT_NULL;
                     phase_in = PH_LIT;
                  end else if (doc_byte == 8'h2d) begin
                     neg_in   = 1'b1;
                     phase_in = PH_NUM;
                  end else if (is_digit(doc_byte)) begin
                     mag_in   = {60'b0, doc_byte[3:0]};
                     phase_in = PH_NUM;
                  end else begin
                     do_err = 1'b1;
                  end
               end
               PH_LIT: begin
                  if (litpos_ff < lit_len(litw_ff) &&
                      doc_byte == lit_char(litw_ff, litpos_ff)) begin
                     litpos_in = litpos_ff + 3'd1;
                     if (litpos_in == lit_len(litw_ff)) begin
                        if (litw_ff == LIT_NULL) begin
                           ev_a[n].kind = EV_NULL;
                        end else begin
                           ev_a[n].kind = EV_BOOL;
                           ev_a[n].data = {63'b0, litw_ff == LIT_TRUE};
                        end
                        n = n + 2'd1;
                        phase_in = PH_OBJ_AFTER;
                     end
                  end else begin
                     do_err = 1'b1;
                  end
               end
               PH_OBJ_AFTER: begin
                  if (doc_byte == 8'h2c) phase_in = PH_OBJ_KEY;
                  else if (doc_byte == 8'h7d) do_close_obj = 1'b1;
                  else do_err = 1'b1;
               end
               PH_ARR_AFTER: begin
                  if (doc_byte == 8'h2c) phase_in = PH_ARR_OBJ;
                  else if (doc_byte == 8'h5d) do_close_arr = 1'b1;
                  else do_err = 1'b1;
               end
               default: begin
               end
            endcase
         end

         // structural actions shared by several phases
         if (do_open) begin
            ev_a[n].kind = EV_OBJ_OPEN;
            n = n + 2'd1;
            inobj_in = 1'b1;
            phase_in = PH_OBJ_FIRST;
         end
         if (do_close_obj) begin
            inobj_in = 1'b0;
            ev_a[n].kind = EV_OBJ_CLOSE;
            if (array_mode) begin
               phase_in = PH_ARR_AFTER;
            end else begin
               ev_a[n].fin = 1'b1;
               phase_in  = PH_DONE;
               closed_in = 1'b1;
            end
            n = n + 2'd1;
         end
         if (do_close_arr) begin
            ev_a[n].kind = EV_ARR_CLOSE;
            ev_a[n].fin  = 1'b1;
            n = n + 2'd1;
            phase_in  = PH_DONE;
            closed_in = 1'b1;
         end
         if (do_err) begin
            ev_a[n].kind = EV_ERROR;
            n = n + 2'd1;
            err_in = 1'b1;
         end
      end

      // end of document: incomplete check, then rearm
      if (doc_last) begin
         if (!err_in && !closed_in) begin
            ev_a[n].kind = EV_ERROR;
            n = n + 2'd1;
         end
         phase_in  = PH_START;
         inobj_in  = 1'b0;
         esc_in    = 1'b0;
         litpos_in = 3'd0;
         litw_in   = 2'd0;
         mag_in    = 64'd0;
         neg_in    = 1'b0;
         ovf_in    = 1'b0;
         closed_in = 1'b0;
         err_in    = 1'b0;
      end

      if (n != 2'd0) begin
         ev_a[n - 2'd1].last = 1'b1;
      end
      bundle.count = n;
      bundle.ev    = ev_a;
   end

   // state update on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         inobj_ff  <= 1'b0;
         esc_ff    <= 1'b0;
         litpos_ff <= 3'd0;
         litw_ff   <= 2'd0;
         mag_ff    <= 64'd0;
         neg_ff    <= 1'b0;
         ovf_ff    <= 1'b0;
         closed_ff <= 1'b0;
         err_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         inobj_ff  <= inobj_in;
         esc_ff    <= esc_in;
         litpos_ff <= litpos_in;
         litw_ff   <= litw_in;
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
         ovf_ff    <= ovf_in;
         closed_ff <= closed_in;
         err_ff    <= err_in;
      end
   end

   `FJSP_ASSERT_IMP(a_closed_done, closed_ff, (phase_ff == PH_DONE) && !inobj_ff, "closed document not in done phase")
   `FJSP_ASSERT_NXT(a_rearm, advance && doc_last, (phase_ff == PH_START) && !err_ff && !closed_ff, "parser did not rearm")

endmodule

>>> design/fjsp_emit.sv
// result buffer: holds the events of one byte and hands them out one per cycle while results are accepted
`include "flat_json_stream_parser_macros.svh"

module fjsp_emit
   import fjsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load_valid,
   input  bundle_type  bundle,
   output logic        can_load,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // event_data
   output logic [4:0]  rsp_tuser,   // event_kind[3:0], finished[4]
   output logic        rsp_tlast    // last_in_run
);

   logic [1:0]              cnt_ff, cnt_in;
   ev_type [MAX_EVENTS-1:0] slot_ff, slot_in;
   logic                    drain;
   logic                    load;

   assign drain    = (cnt_ff != 2'd0) && rsp_tready;
   assign can_load = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign load     = load_valid && (bundle.count != 2'd0);

   // load a fresh bundle or shift down after each output transaction
   always_comb begin
      cnt_in  = cnt_ff;
      slot_in = slot_ff;
      if (load) begin
         cnt_in  = bundle.count;
         slot_in = bundle.ev;
      end else if (drain) begin
         cnt_in     = cnt_ff - 2'd1;
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // head slot drives the result port
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = slot_ff[0].data;
   assign rsp_tuser  = {slot_ff[0].fin, slot_ff[0].kind};
   assign rsp_tlast  = slot_ff[0].last;

   `FJSP_ASSERT_IMP(a_no_overwrite, load, (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && drain), "pending event overwritten")
   `FJSP_ASSERT_IMP(a_last_on_final, cnt_ff != 2'd0, slot_ff[0].last == (cnt_ff == 2'd1), "run marker misplaced")
   `FJSP_ASSERT_IMP(a_fin_on_close, (cnt_ff != 2'd0) && slot_ff[0].fin, (slot_ff[0].kind == EV_OBJ_CLOSE) || (slot_ff[0].kind == EV_ARR_CLOSE), "finished on non-close event")

endmodule
